FILE: hdl/mpsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the multiprecision small-operand ALU.
package mpsa_pkg;

  // Field widths
  localparam int OPCODE_W  = 3;
  localparam int INDEX_W   = 4;
  localparam int BYTE_W    = 8;
  localparam int OPERAND_W = 16;
  localparam int ACTIVE_W  = 5;
  localparam int MAC_W     = BYTE_W + OPERAND_W;

  // Store defaults
  localparam int DEF_MAX_DIGITS = 16;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  // Opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD = 3'd0,
    OP_DIV  = 3'd1,
    OP_MUL  = 3'd2,
    OP_ADD  = 3'd3,
    OP_READ = 3'd4
  } op_t;

endpackage

FILE: hdl/mpsa_unit.sv
`timescale 1ns / 1ps
// Shared arithmetic unit: byte multiply-accumulate and one restoring divide step.
module mpsa_unit (
  input  logic [mpsa_pkg::BYTE_W-1:0]    byte_in,
  input  logic [mpsa_pkg::OPERAND_W-1:0] multiplier,
  input  logic [mpsa_pkg::OPERAND_W-1:0] carry_in,
  output logic [mpsa_pkg::MAC_W-1:0]     mac_out,
  input  logic [mpsa_pkg::OPERAND_W-1:0] rem_in,
  input  logic                           bit_in,
  input  logic [mpsa_pkg::OPERAND_W-1:0] divisor,
  output logic [mpsa_pkg::OPERAND_W-1:0] rem_out,
  output logic                           q_bit
);
  import mpsa_pkg::*;

  logic [OPERAND_W:0] trial;
  logic [OPERAND_W:0] diff;

  // byte * multiplier + carry, never exceeds 24 bits
  assign mac_out = MAC_W'(byte_in) * MAC_W'(multiplier) + MAC_W'(carry_in);

  // shift in one dividend bit, subtract the divisor where it fits
  assign trial   = {rem_in, bit_in};
  assign diff    = trial - {1'b0, divisor};
  assign q_bit   = (trial >= {1'b0, divisor});
  assign rem_out = q_bit ? diff[OPERAND_W-1:0] : trial[OPERAND_W-1:0];

endmodule

FILE: hdl/mpsa_seq.sv
`timescale 1ns / 1ps
// Sequencer and digit store: walks the active bytes through the shared unit.
module mpsa_seq #(
  parameter int MAX_DIGITS = mpsa_pkg::DEF_MAX_DIGITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [mpsa_pkg::ACTIVE_W-1:0]   digits,
  input  logic                            start,
  input  logic [mpsa_pkg::OPCODE_W-1:0]   opcode,
  input  logic [mpsa_pkg::INDEX_W-1:0]    byte_index,
  input  logic [mpsa_pkg::BYTE_W-1:0]     load_byte,
  input  logic [mpsa_pkg::OPERAND_W-1:0]  operand,
  output logic                            busy,
  output logic                            done,
  output logic [mpsa_pkg::BYTE_W-1:0]     read_byte,
  output logic [mpsa_pkg::OPERAND_W-1:0]  remainder,
  output logic                            was_nonzero,
  output logic                            overflow,
  output logic                            bad_operand
);
  import mpsa_pkg::*;

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MAC,
    S_DLOAD,
    S_DBIT
  } state_t;

  state_t               state;
  logic [OPCODE_W-1:0]  op_q;
  logic [INDEX_W-1:0]   idx_q;
  logic [OPERAND_W-1:0] opnd_q;
  logic [ACTIVE_W-1:0]  n_q;
  logic [ACTIVE_W-1:0]  pos;
  logic [2:0]           cnt;
  logic [BYTE_W-1:0]    qs;
  logic [OPERAND_W-1:0] rem;
  logic [OPERAND_W-1:0] carry;
  logic                 nz;

  // digit store
  logic [BYTE_W-1:0]     mem [MAX_DIGITS];
  logic [MAX_DIGITS-1:0] valid;
  logic [BYTE_W-1:0]     rdata;
  logic                  rvalid;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [BYTE_W-1:0]     wdata;
  logic [AW-1:0]         raddr;
  logic [BYTE_W-1:0]     byte_cur;

  // unit connections
  logic [OPERAND_W-1:0] mult;
  logic [MAC_W-1:0]     mac_out;
  logic [OPERAND_W-1:0] rem_out;
  logic                 q_bit;
  logic [BYTE_W-1:0]    q_byte;

  logic accept;
  logic idx_in_store;
  logic idx_q_in_store;
  logic last_digit;

  assign busy           = (state != S_IDLE);
  assign accept         = start && (state == S_IDLE);
  assign idx_in_store   = (32'(byte_index) < MAX_DIGITS);
  assign idx_q_in_store = (32'(idx_q) < MAX_DIGITS);
  assign byte_cur       = rvalid ? rdata : '0;
  assign mult           = (op_q == OP_ADD) ? OPERAND_W'(1) : opnd_q;
  assign q_byte         = {qs[BYTE_W-2:0], q_bit};
  assign last_digit     = (pos == n_q - ACTIVE_W'(1));

  mpsa_unit u_unit (
    .byte_in    (byte_cur),
    .multiplier (mult),
    .carry_in   (carry),
    .mac_out    (mac_out),
    .rem_in     (rem),
    .bit_in     (qs[BYTE_W-1]),
    .divisor    (opnd_q),
    .rem_out    (rem_out),
    .q_bit      (q_bit)
  );

  // store write port
  always_comb begin
    we    = 1'b0;
    waddr = AW'(pos);
    wdata = mac_out[BYTE_W-1:0];
    unique case (state)
      S_IDLE: begin
        we    = accept && (opcode == OP_LOAD) && idx_in_store;
        waddr = AW'(byte_index);
        wdata = load_byte;
      end
      S_MAC: begin
        we = 1'b1;
      end
      S_DBIT: begin
        we    = (cnt == 3'd7);
        wdata = q_byte;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // store read address, presented in the cycle before the byte that is needed
  always_comb begin
    unique case (state)
      S_IDLE: begin
        if (opcode == OP_DIV) begin
          raddr = '0;
        end else if (opcode == OP_READ) begin
          raddr = AW'(byte_index);
        end else begin
          raddr = AW'(digits - ACTIVE_W'(1));
        end
      end
      S_MAC:   raddr = AW'(pos - ACTIVE_W'(1));
      S_DBIT:  raddr = AW'(pos + ACTIVE_W'(1));
      default: raddr = AW'(pos);
    endcase
  end

  // memory array with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata  <= mem[raddr];
    rvalid <= valid[raddr];
  end

  // per-byte valid bits stand in for the all-zero reset of the store
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q        <= opcode;
            idx_q       <= byte_index;
            opnd_q      <= operand;
            n_q         <= digits;
            read_byte   <= '0;
            remainder   <= '0;
            was_nonzero <= 1'b0;
            overflow    <= 1'b0;
            bad_operand <= 1'b0;
            unique case (opcode)
              OP_READ: begin
                state <= S_READ;
              end
              OP_DIV: begin
                if (operand == '0) begin
                  bad_operand <= 1'b1;
                  done        <= 1'b1;
                end else if (digits == '0) begin
                  done <= 1'b1;
                end else begin
                  pos   <= '0;
                  rem   <= '0;
                  nz    <= 1'b0;
                  state <= S_DLOAD;
                end
              end
              OP_MUL, OP_ADD: begin
                if (digits == '0) begin
                  overflow <= (opcode == OP_ADD) && (operand != '0);
                  done     <= 1'b1;
                end else begin
                  pos   <= digits - ACTIVE_W'(1);
                  carry <= (opcode == OP_ADD) ? operand : '0;
                  state <= S_MAC;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          read_byte <= idx_q_in_store ? byte_cur : '0;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_MAC: begin
          carry <= mac_out[MAC_W-1:BYTE_W];
          if (pos == '0) begin
            overflow <= (mac_out[MAC_W-1:BYTE_W] != '0);
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            pos <= pos - ACTIVE_W'(1);
          end
        end
        S_DLOAD: begin
          qs    <= byte_cur;
          nz    <= nz || (byte_cur != '0);
          cnt   <= '0;
          state <= S_DBIT;
        end
        S_DBIT: begin
          rem <= rem_out;
          qs  <= q_byte;
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            if (last_digit) begin
              remainder   <= rem_out;
              was_nonzero <= nz;
              done        <= 1'b1;
              state       <= S_IDLE;
            end else begin
              pos   <= pos + ACTIVE_W'(1);
              state <= S_DLOAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a multi-cycle arithmetic item keeps the block busy on the next cycle
  a_arith_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (opcode == OP_MUL || opcode == OP_ADD) && (digits != '0) |=> busy)
    else $error("multiply or add did not start the byte walk");

  // a divide result never reaches its divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    done && (op_q == OP_DIV) && !bad_operand |-> (remainder < opnd_q))
    else $error("remainder not below divisor");

  // a rejected divide carries no other result
  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    done && bad_operand |-> (remainder == '0) && !was_nonzero && !overflow)
    else $error("zero divisor result not clean");

  // the divide step stays in the quotient bit state until its counter reaches the last bit
  a_cnt_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DBIT) && (cnt != 3'd7) |=> (state == S_DBIT))
    else $error("divide step left early");

endmodule

FILE: hdl/multiprecision_small_operand_alu.sv
`timescale 1ns / 1ps
// Top level: configuration register port and the multiprecision ALU sequencer.
//
// Usage: an item is transferred when start is high and busy is low; its single
// result appears on the result ports for exactly one cycle with done high, and
// the receiver cannot stall it. Load, unused opcodes, a divide by zero and any
// arithmetic with zero active digits give their result in the cycle after the
// transfer with busy staying low. A read passes through a read state that takes
// the stored byte before its result. Multiply and add walk the n active bytes
// through one shared 8x16 multiply-accumulate, one byte a cycle. Divide runs
// one restoring quotient bit a cycle, pausing for a store read state before
// each byte. The digit store is a memory with one read and one write port;
// its reset to zero takes effect at once.
module multiprecision_small_operand_alu #(
  parameter int MAX_DIGITS = mpsa_pkg::DEF_MAX_DIGITS
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // command
  input  logic                            start,
  output logic                            busy,
  input  logic [mpsa_pkg::OPCODE_W-1:0]   opcode,
  input  logic [mpsa_pkg::INDEX_W-1:0]    byte_index,
  input  logic [mpsa_pkg::BYTE_W-1:0]     load_byte,
  input  logic [mpsa_pkg::OPERAND_W-1:0]  operand,
  // result
  output logic                            done,
  output logic [mpsa_pkg::BYTE_W-1:0]     read_byte,
  output logic [mpsa_pkg::OPERAND_W-1:0]  remainder,
  output logic                            was_nonzero,
  output logic                            overflow,
  output logic                            bad_operand
);
  import mpsa_pkg::*;

  localparam logic [2:0] ADDR_ACTIVE = 3'd0;

  logic [ACTIVE_W-1:0] active_digits;
  logic [ACTIVE_W-1:0] used_digits;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_ACTIVE);

  // active digit register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_digits <= ACTIVE_RESET;
    end else if (cfg_write) begin
      active_digits <= pwdata[ACTIVE_W-1:0];
    end
  end

  // register read back
  assign prdata = (paddr == ADDR_ACTIVE) ? {{(32-ACTIVE_W){1'b0}}, active_digits} : '0;

  // digits beyond the store saturate
  assign used_digits = (32'(active_digits) > MAX_DIGITS) ? ACTIVE_W'(MAX_DIGITS)
                                                         : active_digits;

  mpsa_seq #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .digits      (used_digits),
    .start       (start),
    .opcode      (opcode),
    .byte_index  (byte_index),
    .load_byte   (load_byte),
    .operand     (operand),
    .busy        (busy),
    .done        (done),
    .read_byte   (read_byte),
    .remainder   (remainder),
    .was_nonzero (was_nonzero),
    .overflow    (overflow),
    .bad_operand (bad_operand)
  );

endmodule
